@@ hdl/wqt_pkg.sv @@
// ----------------------------------------------------------------------------
// wqt_pkg
// Shared types, request codes and sizes for the windowed quota tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package wqt_pkg;

  localparam int N_INTERVALS = 4;
  localparam int N_RESOURCES = 8;
  localparam int IV_W        = 2;
  localparam int RS_W        = 3;
  localparam int CNT_W       = 64;
  localparam int TIME_W      = 48;
  localparam int DUR_W       = 32;

  // Dividend of the window advance is now - end + length, below 2^49.
  localparam int DIVD_W      = TIME_W + 1;
  localparam int DCNT_W      = 6;

  // Request codes.
  localparam logic [2:0] REQ_USE       = 3'd0;
  localparam logic [2:0] REQ_CHECK     = 3'd1;
  localparam logic [2:0] REQ_CHECK_ALL = 3'd2;
  localparam logic [2:0] REQ_QUERY     = 3'd3;
  localparam logic [2:0] REQ_WR_LIMIT  = 3'd4;
  localparam logic [2:0] REQ_WR_DUR    = 3'd5;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [RS_W-1:0]   resource_sel;
    logic [IV_W-1:0]   interval_sel;
    logic [CNT_W-1:0]  amount;
    logic [TIME_W-1:0] now;
    logic              check_enable;
    logic [CNT_W-1:0]  limit_in;
    logic              limit_enable;
    logic [DUR_W-1:0]  duration_in;
  } wqt_in_t;

  typedef struct packed {
    logic              exceeded;
    logic [IV_W-1:0]   hit_interval;
    logic [RS_W-1:0]   hit_resource;
    logic [CNT_W-1:0]  used_out;
    logic [CNT_W-1:0]  limit_out;
    logic              limited_out;
    logic [TIME_W-1:0] end_out;
    logic [DUR_W-1:0]  duration_out;
  } wqt_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;
    logic            add;
    logic            div_start;
    logic            apply;
    logic            write;
    logic            report;
    logic            zero;
    logic            hit;
    logic [IV_W-1:0] iv;
    logic [RS_W-1:0] rs;
    logic [IV_W-1:0] rpt_iv;
  } wqt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0]      req_type;
    logic [RS_W-1:0] rs_sel;
    logic [IV_W-1:0] isel;
    logic            chk;
    logic            limited;
    logic            over;
    logic            expired;
    logic            div_done;
  } wqt_sts_t;

endpackage

`default_nettype wire

@@ hdl/wqt_dp.sv @@
// ----------------------------------------------------------------------------
// wqt_dp
// Datapath: usage counters, limits, window state, the remainder unit for
// window advance and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wqt_dp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire wqt_pkg::wqt_in_t in_item,
  input  wire wqt_pkg::wqt_cmd_t cmd,
  output wqt_pkg::wqt_sts_t     sts,
  output logic                  out_strobe,
  output wqt_pkg::wqt_out_t     out_item
);

  localparam int NI = wqt_pkg::N_INTERVALS;
  localparam int NR = wqt_pkg::N_RESOURCES;

  // Table state.
  logic [wqt_pkg::CNT_W-1:0]  cnt_r   [NI][NR];
  logic [wqt_pkg::CNT_W-1:0]  lim_r   [NI][NR];
  logic                       limd_r  [NI][NR];
  logic [wqt_pkg::DUR_W-1:0]  len_r   [NI];
  logic [wqt_pkg::TIME_W-1:0] end_r   [NI];

  // Latched item.
  wqt_pkg::wqt_in_t item_r;

  // Remainder unit.
  logic [wqt_pkg::DIVD_W-1:0] divd_r;
  logic [wqt_pkg::DUR_W-1:0]  rem_r;
  logic [wqt_pkg::DCNT_W-1:0] dcnt_r;

  logic                       out_strobe_r;
  wqt_pkg::wqt_out_t          out_r;

  logic [wqt_pkg::CNT_W-1:0]  cur_cnt;
  logic [wqt_pkg::CNT_W-1:0]  cur_lim;
  logic [wqt_pkg::DUR_W-1:0]  cur_len;
  logic [wqt_pkg::TIME_W-1:0] cur_end;
  logic [wqt_pkg::DIVD_W-1:0] divd_init;
  logic [wqt_pkg::DUR_W:0]    rem_sh;
  logic [wqt_pkg::DUR_W:0]    rem_sub;
  logic [wqt_pkg::TIME_W+1:0] new_end_w;
  logic [wqt_pkg::TIME_W-1:0] new_end;
  logic                       rpt_fresh;

  // Entry selected by the controller.
  assign cur_cnt = cnt_r[cmd.iv][cmd.rs];
  assign cur_lim = lim_r[cmd.iv][cmd.rs];
  assign cur_len = len_r[cmd.iv];
  assign cur_end = end_r[cmd.iv];

  // A report in the cycle its interval advances sees the advanced window.
  assign rpt_fresh = cmd.apply && (cmd.rpt_iv == cmd.iv);

  // Status for the controller.
  always_comb begin
    sts.req_type = item_r.req_type;
    sts.rs_sel   = item_r.resource_sel;
    sts.isel     = item_r.interval_sel;
    sts.chk      = item_r.check_enable;
    sts.limited  = limd_r[cmd.iv][cmd.rs];
    sts.over     = cur_cnt > cur_lim;
    sts.expired  = item_r.now >= cur_end;
    sts.div_done = (dcnt_r == '0);
  end

  // Window advance: new end = now + len - ((now - end + len) mod len).
  always_comb begin
    divd_init = {1'b0, item_r.now} - {1'b0, cur_end}
                + {{(wqt_pkg::DIVD_W-wqt_pkg::DUR_W){1'b0}}, cur_len};
    rem_sh    = {rem_r, divd_r[wqt_pkg::DIVD_W-1]};
    rem_sub   = rem_sh - {1'b0, cur_len};
    new_end_w = {2'b00, item_r.now}
                + {{(wqt_pkg::TIME_W+2-wqt_pkg::DUR_W){1'b0}}, cur_len}
                - {{(wqt_pkg::TIME_W+2-wqt_pkg::DUR_W){1'b0}}, rem_r};
    if (new_end_w[wqt_pkg::TIME_W+1:wqt_pkg::TIME_W] != 2'b00) begin
      new_end = '1;
    end else begin
      new_end = new_end_w[wqt_pkg::TIME_W-1:0];
    end
  end

  // Item latch and remainder iterations, one dividend bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      divd_r <= divd_init;
      rem_r  <= '0;
      dcnt_r <= wqt_pkg::DCNT_W'(wqt_pkg::DIVD_W);
    end else if (dcnt_r != '0) begin
      divd_r <= {divd_r[wqt_pkg::DIVD_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, cur_len}) begin
        rem_r <= rem_sub[wqt_pkg::DUR_W-1:0];
      end else begin
        rem_r <= rem_sh[wqt_pkg::DUR_W-1:0];
      end
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  // Table updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NI; i++) begin
        len_r[i] <= wqt_pkg::DUR_W'(1);
        end_r[i] <= '0;
        for (int j = 0; j < NR; j++) begin
          cnt_r[i][j]  <= '0;
          lim_r[i][j]  <= '0;
          limd_r[i][j] <= 1'b0;
        end
      end
    end else begin
      if (cmd.add) begin
        cnt_r[cmd.iv][cmd.rs] <= cur_cnt + item_r.amount;
      end
      if (cmd.apply) begin
        end_r[cmd.iv] <= new_end;
        for (int j = 0; j < NR; j++) begin
          cnt_r[cmd.iv][j] <= '0;
        end
      end
      if (cmd.write) begin
        if (item_r.req_type == wqt_pkg::REQ_WR_LIMIT) begin
          lim_r[item_r.interval_sel][item_r.resource_sel]  <= item_r.limit_in;
          limd_r[item_r.interval_sel][item_r.resource_sel] <= item_r.limit_enable;
        end else begin
          if (item_r.duration_in == '0) begin
            len_r[item_r.interval_sel] <= wqt_pkg::DUR_W'(1);
          end else begin
            len_r[item_r.interval_sel] <= item_r.duration_in;
          end
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.report | cmd.zero;
    end
    if (cmd.report) begin
      out_r.exceeded     <= cmd.hit;
      out_r.hit_interval <= cmd.rpt_iv;
      out_r.hit_resource <= cmd.rs;
      out_r.used_out     <= rpt_fresh ? '0 : cnt_r[cmd.rpt_iv][cmd.rs];
      out_r.limit_out    <= lim_r[cmd.rpt_iv][cmd.rs];
      out_r.limited_out  <= limd_r[cmd.rpt_iv][cmd.rs];
      out_r.end_out      <= rpt_fresh ? new_end : end_r[cmd.rpt_iv];
      out_r.duration_out <= len_r[cmd.rpt_iv];
    end else if (cmd.zero) begin
      out_r <= '0;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

`default_nettype wire

@@ hdl/wqt_ctrl.sv @@
// ----------------------------------------------------------------------------
// wqt_ctrl
// Controller: walks intervals and resources for each item and sequences
// the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module wqt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire wqt_pkg::wqt_sts_t sts,
  output wqt_pkg::wqt_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_APPLY = 3'd5;
  localparam logic [2:0] S_ADD2  = 3'd6;
  localparam logic [2:0] S_EVAL2 = 3'd7;

  localparam logic [wqt_pkg::IV_W-1:0] IV_LAST = wqt_pkg::IV_W'(wqt_pkg::N_INTERVALS - 1);
  localparam logic [wqt_pkg::RS_W-1:0] RS_LAST = wqt_pkg::RS_W'(wqt_pkg::N_RESOURCES - 1);

  logic [2:0]               state_r, state_nxt;
  logic [wqt_pkg::IV_W-1:0] iv_r, iv_nxt;
  logic [wqt_pkg::RS_W-1:0] rs_r, rs_nxt;
  logic                     adv;
  logic                     is_use;

  assign is_use = (sts.req_type == wqt_pkg::REQ_USE);

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    iv_nxt     = iv_r;
    rs_nxt     = rs_r;
    adv        = 1'b0;
    cmd        = '0;
    cmd.iv     = iv_r;
    cmd.rs     = rs_r;
    cmd.rpt_iv = iv_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        iv_nxt = '0;
        rs_nxt = (sts.req_type == wqt_pkg::REQ_CHECK_ALL) ? '0 : sts.rs_sel;
        priority if (is_use) begin
          state_nxt = S_ADD;
        end else if (sts.req_type == wqt_pkg::REQ_CHECK ||
                     sts.req_type == wqt_pkg::REQ_CHECK_ALL ||
                     sts.req_type == wqt_pkg::REQ_QUERY) begin
          state_nxt = S_EVAL;
        end else if (sts.req_type == wqt_pkg::REQ_WR_LIMIT ||
                     sts.req_type == wqt_pkg::REQ_WR_DUR) begin
          cmd.write = 1'b1;
          cmd.zero  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.zero  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.req_type == wqt_pkg::REQ_QUERY) begin
          // Query only advances expired windows.
          if (sts.expired) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            adv = 1'b1;
          end
        end else if (sts.limited && sts.over) begin
          if (sts.expired) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else if (!is_use || sts.chk) begin
            cmd.report = 1'b1;
            cmd.hit    = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            adv = 1'b1;
          end
        end else begin
          adv = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (is_use) begin
          state_nxt = S_ADD2;
        end else begin
          adv = 1'b1;
        end
      end
      S_ADD2: begin
        cmd.add   = 1'b1;
        state_nxt = S_EVAL2;
      end
      S_EVAL2: begin
        if (sts.over && sts.chk) begin
          cmd.report = 1'b1;
          cmd.hit    = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          adv = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Step to the next interval, the next resource, or finish.
    if (adv) begin
      priority if (iv_r != IV_LAST) begin
        iv_nxt    = iv_r + 1'b1;
        state_nxt = is_use ? S_ADD : S_EVAL;
      end else if (sts.req_type == wqt_pkg::REQ_CHECK_ALL && rs_r != RS_LAST) begin
        rs_nxt    = rs_r + 1'b1;
        iv_nxt    = '0;
        state_nxt = S_EVAL;
      end else if (sts.req_type == wqt_pkg::REQ_QUERY) begin
        cmd.report = 1'b1;
        cmd.rpt_iv = sts.isel;
        state_nxt  = S_IDLE;
      end else begin
        cmd.zero  = 1'b1;
        state_nxt = S_IDLE;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iv_r    <= '0;
      rs_r    <= '0;
    end else begin
      state_r <= state_nxt;
      iv_r    <= iv_nxt;
      rs_r    <= rs_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

@@ hdl/windowed_quota_tracker.sv @@
// ----------------------------------------------------------------------------
// windowed_quota_tracker
// Fixed-window quota tracker with per-interval usage counters and limits.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears for one cycle with out_strobe high and cannot be held off, so the
// receiver must take it in that cycle. busy is already low in the strobe
// cycle, so the next item can be taken there. Each window that is advanced
// goes through the one-bit-per-cycle remainder unit that finds the new
// window end. A window is advanced at most once per item, and a check-all
// visits up to all 32 interval and resource pairs.
`default_nettype none

module windowed_quota_tracker (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire wqt_pkg::wqt_in_t in_item,
  output logic                  out_strobe,
  output wqt_pkg::wqt_out_t     out_item
);

  wqt_pkg::wqt_cmd_t cmd;
  wqt_pkg::wqt_sts_t sts;

  wqt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  wqt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire
